### hw/rtl/two_stack_queue_core_defines.svh
// Assertion macros used by two_stack_queue_core to check the queue.
`ifndef TWO_STACK_QUEUE_CORE_DEFINES_SVH
`define TWO_STACK_QUEUE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("two_stack_queue check failed");

// The consequent must hold in the cycle after the antecedent.
`define TSQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("two_stack_queue check failed");

`endif

### hw/rtl/tsq_pkg.sv
package tsq_pkg;

  // Operation codes of the func field.
  typedef enum logic [1:0] {
    FUNC_ENQ  = 2'd0,
    FUNC_DEQ  = 2'd1,
    FUNC_PEEK = 2'd2
  } func_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_XFER = 2'd1,
    S_READ = 2'd2,
    S_WAIT = 2'd3
  } state_e;

  localparam int unsigned CapWidth   = 5;
  localparam int unsigned OutWidth   = 32;
  localparam int unsigned CountWidth = 5;
  localparam logic [CapWidth-1:0] CapReset = 5'd16;

  // Result request from the sequencer to the output register.
  typedef struct packed {
    logic    valid;
    status_e status;
    logic    take_rd;
  } resp_t;

endpackage

### hw/rtl/tsq_ram.sv
module tsq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/tsq_ctrl.sv
module tsq_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [1:0]                         func_i,
  input  logic [tsq_pkg::CapWidth-1:0]       cap_i,
  output logic                               busy_o,
  output tsq_pkg::resp_t                     resp_o,
  output logic                               in_we_o,
  output logic [$clog2(DEPTH)-1:0]           in_waddr_o,
  output logic [$clog2(DEPTH)-1:0]           in_raddr_o,
  output logic                               out_we_o,
  output logic [$clog2(DEPTH)-1:0]           out_waddr_o,
  output logic [$clog2(DEPTH)-1:0]           out_raddr_o,
  output logic [$clog2(DEPTH+1)-1:0]         total_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned TW = (CW > tsq_pkg::CapWidth) ? CW : tsq_pkg::CapWidth;

  tsq_pkg::state_e state_q, state_d;
  logic [CW-1:0]   in_q, in_d;
  logic [CW-1:0]   out_q, out_d;
  logic            deq_q, deq_d;
  logic            pend_q, pend_d;

  logic [CW-1:0] total;
  logic [TW-1:0] cap_ext;
  logic [TW-1:0] eff_cap;
  logic          full;

  assign total   = in_q + out_q;
  assign cap_ext = TW'(cap_i);
  assign eff_cap = (cap_ext > TW'(DEPTH)) ? TW'(DEPTH) : cap_ext;
  assign full    = (TW'(total) >= eff_cap) || (in_q == CW'(DEPTH));

  assign in_waddr_o  = AW'(in_q);
  assign in_raddr_o  = AW'(in_q - CW'(1));
  assign out_waddr_o = AW'(out_q);
  assign out_raddr_o = AW'(out_q - CW'(1));
  assign total_o     = total;
  assign busy_o      = (state_q != tsq_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsq_pkg::S_IDLE;
      in_q    <= '0;
      out_q   <= '0;
      deq_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      in_q    <= in_d;
      out_q   <= out_d;
      deq_q   <= deq_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_d           = in_q;
    out_d          = out_q;
    deq_d          = deq_q;
    pend_d         = 1'b0;
    in_we_o        = 1'b0;
    out_we_o       = 1'b0;
    resp_o.valid   = 1'b0;
    resp_o.status  = tsq_pkg::STAT_OK;
    resp_o.take_rd = 1'b0;
    case (state_q)
      tsq_pkg::S_IDLE: begin
        if (start_i) begin
          deq_d = (tsq_pkg::func_e'(func_i) == tsq_pkg::FUNC_DEQ);
          case (tsq_pkg::func_e'(func_i))
            tsq_pkg::FUNC_ENQ: begin
              resp_o.valid = 1'b1;
              if (full) begin
                resp_o.status = tsq_pkg::STAT_FULL;
              end else begin
                in_we_o = 1'b1;
                in_d    = in_q + CW'(1);
              end
            end
            tsq_pkg::FUNC_DEQ, tsq_pkg::FUNC_PEEK: begin
              if (total == '0) begin
                resp_o.valid  = 1'b1;
                resp_o.status = tsq_pkg::STAT_EMPTY;
              end else if (out_q == '0) begin
                state_d = tsq_pkg::S_XFER;
              end else begin
                if (tsq_pkg::func_e'(func_i) == tsq_pkg::FUNC_DEQ) begin
                  out_d = out_q - CW'(1);
                end
                state_d = tsq_pkg::S_WAIT;
              end
            end
            default: begin
              resp_o.valid = 1'b1;
            end
          endcase
        end
      end
      tsq_pkg::S_XFER: begin
        // Pop one inbound word per cycle; push it in the next cycle.
        if (in_q != '0) begin
          in_d   = in_q - CW'(1);
          pend_d = 1'b1;
        end
        if (pend_q) begin
          out_we_o = 1'b1;
          out_d    = out_q + CW'(1);
        end
        if ((in_q == '0) && !pend_q) begin
          state_d = tsq_pkg::S_READ;
        end
      end
      tsq_pkg::S_READ: begin
        if (deq_q) begin
          out_d = out_q - CW'(1);
        end
        state_d = tsq_pkg::S_WAIT;
      end
      tsq_pkg::S_WAIT: begin
        resp_o.valid   = 1'b1;
        resp_o.take_rd = 1'b1;
        state_d        = tsq_pkg::S_IDLE;
      end
      default: begin
        state_d = tsq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/two_stack_queue_core.sv
// Enqueue, full, empty and unused codes: result in the cycle after start, next start at once.
// Dequeue or peek with words on the outbound stack: busy for one cycle, result after the
// wait state and result register, from the registered read port of the outbound RAM.
// Refilling dequeue or peek: n inbound words move one per cycle, then read and wait states.
// Reset clears both stack counters and sets the capacity to 16; RAM contents are not cleared.
// The receiver cannot stall: done_o pulses for one cycle with the result.
`include "two_stack_queue_core_defines.svh"

module two_stack_queue_core #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Command channel.
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       func_i,
  input  logic signed [31:0]               value_i,
  // Result channel.
  output logic                             done_o,
  output logic signed [31:0]               data_o,
  output logic [1:0]                       status_o,
  output logic [tsq_pkg::CountWidth-1:0]   count_o,
  output logic                             is_empty_o,
  // Capacity register write channel.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [tsq_pkg::CapWidth-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > tsq_pkg::CountWidth) ? CW : tsq_pkg::CountWidth;
  localparam int unsigned DW = (DATA_WIDTH > tsq_pkg::OutWidth) ? DATA_WIDTH : tsq_pkg::OutWidth;

  // The capacity register. Values above DEPTH are clipped in the sequencer.
  logic [tsq_pkg::CapWidth-1:0] cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= tsq_pkg::CapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      cap_q <= cfg_data_i;
    end
  end

  // Configuration is taken whenever no operation is in flight.
  assign cfg_ready_o = !busy;

  // Sequencer and stack counters.
  tsq_pkg::resp_t  resp;
  logic            in_we, out_we;
  logic [AW-1:0]   in_waddr, in_raddr, out_waddr, out_raddr;
  logic [CW-1:0]   total;

  tsq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .func_i     (func_i),
    .cap_i      (cap_q),
    .busy_o     (busy),
    .resp_o     (resp),
    .in_we_o    (in_we),
    .in_waddr_o (in_waddr),
    .in_raddr_o (in_raddr),
    .out_we_o   (out_we),
    .out_waddr_o(out_waddr),
    .out_raddr_o(out_raddr),
    .total_o    (total)
  );

  // The inbound stack stores the low DATA_WIDTH bits of each enqueued word. Its read
  // port serves only the refill, whose data goes straight into the outbound stack.
  logic [DATA_WIDTH-1:0] in_wdata;
  logic [DATA_WIDTH-1:0] in_rdata;
  logic [DATA_WIDTH-1:0] out_rdata;

  assign in_wdata = DATA_WIDTH'($unsigned(value_i));

  tsq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_inbound (
    .clk_i  (clk_i),
    .we_i   (in_we),
    .waddr_i(in_waddr),
    .wdata_i(in_wdata),
    .raddr_i(in_raddr),
    .rdata_o(in_rdata)
  );

  // The outbound stack always reads its top entry, so a dequeue or peek finds the
  // front word on the read port in the cycle after the address settles.
  tsq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_outbound (
    .clk_i  (clk_i),
    .we_i   (out_we),
    .waddr_i(out_waddr),
    .wdata_i(in_rdata),
    .raddr_i(out_raddr),
    .rdata_o(out_rdata)
  );

  // Result register. Data is zero unless the word comes from the outbound stack.
  logic [DW-1:0]                 rd_ext;
  logic                          done_q;
  logic [tsq_pkg::OutWidth-1:0]  data_q;
  tsq_pkg::status_e              status_q;

  assign rd_ext = DW'(out_rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= resp.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.valid) begin
      data_q   <= resp.take_rd ? rd_ext[tsq_pkg::OutWidth-1:0] : '0;
      status_q <= resp.status;
    end
  end

  // During the result cycle the counters already show the state after the word, and
  // they cannot move before the next edge, so count and empty come straight from them.
  logic [KW-1:0] total_ext;

  assign total_ext  = KW'(total);
  assign done_o     = done_q;
  assign data_o     = data_q;
  assign status_o   = status_q;
  assign count_o    = total_ext[tsq_pkg::CountWidth-1:0];
  assign is_empty_o = (total == '0);

  // A result is shown only once the sequencer is back in its idle state.
  `TSQ_ASSERT_SAME(a_done_idle, done_o, !busy)
  // An empty report always comes with an empty queue.
  `TSQ_ASSERT_SAME(a_empty_flag, done_o && (status_o == tsq_pkg::STAT_EMPTY), is_empty_o)
  // A taken word either answers in the next cycle or keeps the block busy.
  `TSQ_ASSERT_NEXT(a_accept_progress, start && !busy, done_o || busy)

endmodule
